// ----- hw/rtl/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the LRU key/value cache: field widths, reset values, FSM and command codes.
// Shared by lkvc_cell, lru_key_value_cache, lkvc_checker and tb_top; depends on nothing else.
package lkvc_pkg;

   // Payload widths
   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 32;
   localparam int CAP_W      = 5;
   localparam int REQ_DATA_W = KEY_W + VALUE_W;
   localparam int RSP_DATA_W = VALUE_W;

   // Defaults and fixed values
   localparam int                 DEFAULT_ENTRIES = 16;
   localparam logic [CAP_W-1:0]   CAP_RESET       = 5'd16;
   localparam logic [VALUE_W-1:0] MISS_VALUE      = '1;

   // Request kinds carried in req_tuser
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_TOUCH,
      CMD_FILL,
      CMD_EVICT
   } cmd_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      cmd_type              cmd;
      logic                 is_put;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } op_type;

   // Hit data rippled along the row of cells
   typedef struct packed {
      logic                 hit;
      logic [VALUE_W-1:0]   value;
   } chain_type;

endpackage

// ----- hw/rtl/lkvc_cell.sv -----
`timescale 1ns / 1ps
// One slot of the LRU cache: stored key, value and recency rank, plus its match flag.
// Depends on lkvc_pkg; instantiated in a row by lru_key_value_cache.
module lkvc_cell #(
   parameter int INDEX  = 0,
   parameter int CNT_W  = 5,
   parameter int RANK_W = 4
) (
   input  logic                  clock,
   input  logic                  lookup_en,
   input  logic [CNT_W-1:0]      count,
   input  lkvc_pkg::op_type      op,
   input  logic [RANK_W-1:0]     ref_rank,
   input  lkvc_pkg::chain_type   chain_prev,
   input  logic [RANK_W-1:0]     rank_prev,
   output lkvc_pkg::chain_type   chain_next,
   output logic [RANK_W-1:0]     rank_next
);
   import lkvc_pkg::*;

   logic [KEY_W-1:0]   key_ff,   key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [RANK_W-1:0]  rank_ff,  rank_in;
   logic               match_ff, match_in;
   logic               filled;
   logic               match;
   logic               older_than_ref;

   assign filled         = CNT_W'(INDEX) < count;
   assign match          = filled && (key_ff == op.key);
   assign older_than_ref = filled && (rank_ff < ref_rank);

   // Pass hit data on to the next cell, merging this slot's match
   always_comb begin
      chain_next.hit   = chain_prev.hit | match;
      chain_next.value = chain_prev.value | (match ? value_ff : '0);
      rank_next        = rank_prev | (match ? rank_ff : '0);
   end

   // Hold the match flag from the lookup cycle for the update cycle
   assign match_in = lookup_en ? match : match_ff;

   // Apply the broadcast command
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      rank_in  = rank_ff;
      unique case (op.cmd)
         CMD_NONE: begin
         end
         CMD_TOUCH: begin
            if (older_than_ref) begin
               rank_in = rank_ff + RANK_W'(1);
            end
            if (match_ff) begin
               rank_in = '0;
               if (op.is_put) begin
                  value_in = op.value;
               end
            end
         end
         CMD_FILL: begin
            if (filled) begin
               rank_in = rank_ff + RANK_W'(1);
            end
            if (CNT_W'(INDEX) == count) begin
               key_in   = op.key;
               value_in = op.value;
               rank_in  = '0;
            end
         end
         CMD_EVICT: begin
            if (older_than_ref) begin
               rank_in = rank_ff + RANK_W'(1);
            end
            if (filled && (rank_ff == ref_rank)) begin
               key_in   = op.key;
               value_in = op.value;
               rank_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      rank_ff  <= rank_in;
      match_ff <= match_in;
   end

endmodule

// ----- hw/rtl/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
// Fully associative LRU key/value cache built as a row of lkvc_cell slots.
// Each request passes a lookup state across the cell row, then an update state that
//   re-ranks the row and loads the response register; the update waits while an earlier
//   response is stalled, and the next request is taken during the update.
// Reset (synchronous): entry count cleared, capacity set to 16, controller idle;
//   cell contents are not cleared, only slots below the entry count are ever used.
module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lkvc_pkg::REQ_DATA_W-1:0] req_tdata,  // lookup_key [31:0], write_value [63:32]
   input  logic                           req_tuser,  // req_type [0]: 0 get, 1 put
   // Response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lkvc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // read_value [31:0]
   output logic                           rsp_tuser,  // hit [0]
   // Configuration
   input  logic                           csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0]     csr_wr_data  // capacity_in_use
);
   import lkvc_pkg::*;

   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CAP_W-1:0]     cap_ff;
   logic                 req_put_ff;
   logic [KEY_W-1:0]     req_key_ff;
   logic [VALUE_W-1:0]   req_value_ff;
   logic                 hit_ff;
   logic [VALUE_W-1:0]   found_value_ff;
   logic [RANK_W-1:0]    found_rank_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;

   logic                 req_accept;
   logic                 lookup_en;
   logic                 update_go;
   logic [CMP_W-1:0]     cap_eff;
   logic                 room_left;
   logic [CNT_W-1:0]     count_minus;
   op_type               op;
   logic [RANK_W-1:0]    ref_rank;
   chain_type            chain_w [ENTRIES+1];
   logic [RANK_W-1:0]    rank_chain_w [ENTRIES+1];

   // Effective capacity clamped to 1..ENTRIES
   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end

   assign room_left   = CMP_W'(count_ff) < cap_eff;
   assign count_minus = count_ff - CNT_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (update_go) begin
               state_in = req_accept ? ST_LOOKUP : ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Controller outputs
   always_comb begin
      lookup_en  = 1'b0;
      update_go  = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_LOOKUP: lookup_en  = 1'b1;
         ST_UPDATE: begin
            update_go  = !rsp_valid_ff || rsp_tready;
            req_tready = update_go;
         end
         default: begin
         end
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   // Choose the command broadcast to the cells
   always_comb begin
      op.cmd    = CMD_NONE;
      op.is_put = req_put_ff;
      op.key    = req_key_ff;
      op.value  = req_value_ff;
      ref_rank  = found_rank_ff;
      count_in  = count_ff;
      if (update_go) begin
         priority if (hit_ff) begin
            op.cmd = CMD_TOUCH;
         end else if (req_put_ff == REQ_PUT && room_left) begin
            op.cmd   = CMD_FILL;
            count_in = count_ff + CNT_W'(1);
         end else if (req_put_ff == REQ_PUT) begin
            op.cmd   = CMD_EVICT;
            ref_rank = count_minus[RANK_W-1:0];
         end else begin
            // get that missed: leave the row untouched
            op.cmd = CMD_NONE;
         end
      end
   end

   // Row of cells with the hit chain running through it
   assign chain_w[0]      = '0;
   assign rank_chain_w[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lkvc_cell #(
         .INDEX  (g),
         .CNT_W  (CNT_W),
         .RANK_W (RANK_W)
      ) u_cell (
         .clock      (clock),
         .lookup_en  (lookup_en),
         .count      (count_ff),
         .op         (op),
         .ref_rank   (ref_rank),
         .chain_prev (chain_w[g]),
         .rank_prev  (rank_chain_w[g]),
         .chain_next (chain_w[g+1]),
         .rank_next  (rank_chain_w[g+1])
      );
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (update_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_put_ff   <= req_tuser;
         req_key_ff   <= req_tdata[KEY_W-1:0];
         req_value_ff <= req_tdata[REQ_DATA_W-1:KEY_W];
      end
   end

   // Hold the lookup outcome for the update cycle
   always_ff @(posedge clock) begin
      if (lookup_en) begin
         hit_ff         <= chain_w[ENTRIES].hit;
         found_value_ff <= chain_w[ENTRIES].value;
         found_rank_ff  <= rank_chain_w[ENTRIES];
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (update_go) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= (hit_ff && req_put_ff == REQ_GET) ? found_value_ff : MISS_VALUE;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_hit_ff;

endmodule

// ----- hw/rtl/lkvc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for lru_key_value_cache, attached with a bind statement.
// Depends on lkvc_pkg and the top-level port list.
module lkvc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [lkvc_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lkvc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            csr_wr_en,
   input logic [lkvc_pkg::CAP_W-1:0]      csr_wr_data
);
   import lkvc_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // One request per lookup/update pair: no transaction right after another
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken during lookup cycle");

   // A miss always returns all ones
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == MISS_VALUE)
      else $error("miss response carries a value");

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache: random get/put traffic with bursty
// requests, stalled responses and capacity changes, checked against an in-bench LRU model.
// Depends on lkvc_pkg and the lru_key_value_cache RTL only.
module tb_top;
   import lkvc_pkg::*;

   localparam int SLOTS         = DEFAULT_ENTRIES;
   localparam int KEY_POOL_SIZE = 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int MAX_PRINTED   = 40;

   typedef struct {
      logic               is_put;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } cache_req_type;

   typedef struct {
      logic               hit;
      logic [VALUE_W-1:0] value;
   } lookup_result_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;  // lookup_key [31:0], write_value [63:32]
   logic                  req_tuser   = REQ_GET;  // req_type [0]
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // read_value [31:0]
   logic                  rsp_tuser;  // hit [0]
   logic                  csr_wr_en   = 1'b0;
   logic [CAP_W-1:0]      csr_wr_data = '0;

   // Stimulus queue and expected responses
   cache_req_type     request_backlog[$];
   lookup_result_type predicted_lookups[$];
   int                error_count = 0;

   // Model of the cache contents
   logic [KEY_W-1:0]   cached_keys[SLOTS];
   logic [VALUE_W-1:0] cached_values[SLOTS];
   int                 age_rank[SLOTS];
   int                 fill_count = 0;
   logic [CAP_W-1:0]   capacity_setting = CAP_RESET;

   // Traffic shaping state
   logic              req_taken  = 1'b0;
   int                burst_left = 0;
   int                gap_left   = 0;
   int                stall_mode = 0;
   int                stall_span = 0;
   logic [KEY_W-1:0]  key_pool[KEY_POOL_SIZE];

   lru_key_value_cache i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (error_count < MAX_PRINTED)
         $display("ERROR @%0t: %s: expected %h, got %h", $time, what, want, got);
      error_count++;
   endtask

   // Promote slot s to most recent among the filled slots
   function automatic void promote_slot(int s);
      int r;
      r = age_rank[s];
      for (int i = 0; i < fill_count; i++) begin
         if (age_rank[i] < r)
            age_rank[i]++;
      end
      age_rank[s] = 0;
   endfunction

   // Apply one request to the model and return the response it should produce
   function automatic lookup_result_type predict_request(cache_req_type r);
      lookup_result_type res;
      int limit;
      int found;
      int victim;
      limit     = (capacity_setting == 0) ? 1 :
                  (capacity_setting > SLOTS) ? SLOTS : int'(capacity_setting);
      found     = -1;
      victim    = 0;
      res.hit   = 1'b0;
      res.value = MISS_VALUE;
      for (int i = 0; i < fill_count; i++) begin
         if (found < 0 && cached_keys[i] == r.key)
            found = i;
      end
      if (found >= 0)
         res.hit = 1'b1;
      if (r.is_put == REQ_GET) begin
         if (found >= 0) begin
            res.value = cached_values[found];
            promote_slot(found);
         end
      end else if (found >= 0) begin
         cached_values[found] = r.value;
         promote_slot(found);
      end else if (fill_count < limit) begin
         // fill a free slot as the most recent entry
         for (int i = 0; i < fill_count; i++)
            age_rank[i]++;
         cached_keys[fill_count]   = r.key;
         cached_values[fill_count] = r.value;
         age_rank[fill_count]      = 0;
         fill_count++;
      end else begin
         // evict the least recent entry
         for (int i = fill_count - 1; i >= 0; i--) begin
            if (age_rank[i] == fill_count - 1)
               victim = i;
         end
         cached_keys[victim]   = r.key;
         cached_values[victim] = r.value;
         promote_slot(victim);
      end
      return res;
   endfunction

   // Drive requests at the falling edge; hold each until the transaction completes
   always @(negedge clock) begin : request_driver
      cache_req_type nxt;
      logic load;
      load = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (request_backlog.size() > 0) begin
            nxt  = request_backlog.pop_front();
            load = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
         req_tvalid <= load;
         if (load) begin
            req_tdata <= {nxt.value, nxt.key};
            req_tuser <= nxt.is_put;
         end
      end
   end

   // Stall responses in spans of a randomly chosen pattern
   always @(negedge clock) begin : response_stall
      if (stall_span == 0) begin
         stall_mode = $urandom_range(3);
         stall_span = $urandom_range(40, 120);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(1));
         end
         2: begin
            rsp_tready <= (stall_span % 4 == 0);
         end
         default: begin
            rsp_tready <= ($urandom_range(3) != 0);
         end
      endcase
   end

   // Sample both channels at the rising edge; check responses, then predict new requests
   always @(posedge clock) begin : cache_monitor
      cache_req_type     seen;
      lookup_result_type want;
      if (reset) begin
         fill_count       = 0;
         capacity_setting = CAP_RESET;
         req_taken       <= 1'b0;
      end else begin
         if (csr_wr_en)
            capacity_setting = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_lookups.size() == 0) begin
               report_mismatch("response with none outstanding", '0, rsp_tdata);
            end else begin
               want = predicted_lookups.pop_front();
               if (rsp_tuser !== want.hit)
                  report_mismatch("hit flag", 32'(want.hit), 32'(rsp_tuser));
               if (rsp_tdata !== want.value)
                  report_mismatch("read value", want.value, rsp_tdata);
            end
         end
         if (req_tvalid && req_tready) begin
            seen.is_put = req_tuser;
            seen.key    = req_tdata[KEY_W-1:0];
            seen.value  = req_tdata[REQ_DATA_W-1:KEY_W];
            predicted_lookups.push_back(predict_request(seen));
         end
         req_taken <= req_tvalid && req_tready;
      end
   end

   task automatic queue_item(logic is_put, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      cache_req_type r;
      r.is_put = is_put;
      r.key    = key;
      r.value  = value;
      request_backlog.push_back(r);
   endtask

   // Mostly keys from a window of the pool three wider than the capacity, so hits are common
   task automatic queue_random(int count, logic [CAP_W-1:0] cap);
      int window;
      int base;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      window = ((cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : int'(cap)) + 3;
      base   = $urandom_range(KEY_POOL_SIZE - 1);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(7) == 0)
            key = $urandom;
         else
            key = key_pool[(base + $urandom_range(window - 1)) % KEY_POOL_SIZE];
         if ($urandom_range(7) == 0)
            value = key_pool[$urandom_range(3)];
         else
            value = $urandom;
         queue_item(1'($urandom_range(1)), key, value);
      end
   endtask

   // Wait until no request is queued, in flight or awaiting its response
   task automatic wait_idle();
      while (request_backlog.size() != 0 || req_tvalid || predicted_lookups.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] cap);
      wait_idle();
      repeat (3) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [CAP_W-1:0]  phase_caps[11] = '{5'd1, 5'd0, 5'd3, 5'd2, 5'd5, 5'd16,
                                            5'd3, 5'd31, 5'd17, 5'd15, 5'd16};
      int                phase_items[11] = '{60, 60, 60, 80, 100, 250, 120, 120, 100, 90, 90};
      int                drained;
      lookup_result_type leftover;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < KEY_POOL_SIZE; i++)
         key_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 11; p++) begin
         set_capacity(phase_caps[p]);
         if (p == 0) begin
            // single entry: miss on empty, fill, update, eviction, get ignoring its data
            queue_item(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
            queue_item(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
            queue_item(REQ_GET, 32'h8000_0000, 32'h0000_0000);
            queue_item(REQ_GET, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
            queue_item(REQ_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
            queue_item(REQ_GET, 32'h8000_0000, 32'h5A5A_5A5A);
            queue_item(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
            queue_item(REQ_GET, 32'h8000_0000, 32'h0000_0000);
            queue_item(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
            queue_item(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
            queue_item(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
            queue_item(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
         end else if (p == 2) begin
            // fill to three, refresh the oldest, then check which entry gets evicted
            queue_item(REQ_PUT, 32'h0000_0001, 32'h1111_1111);
            queue_item(REQ_PUT, 32'h0000_0002, 32'h2222_2222);
            queue_item(REQ_GET, 32'h0000_0000, 32'h0000_0000);
            queue_item(REQ_PUT, 32'h0000_0003, 32'h3333_3333);
            queue_item(REQ_GET, 32'h0000_0001, 32'h0000_0000);
            queue_item(REQ_GET, 32'h0000_0002, 32'h0000_0000);
            queue_item(REQ_GET, 32'h0000_0000, 32'h0000_0000);
         end
         queue_random(phase_items[p], phase_caps[p]);
      end

      // drain with a bound, then flag anything still outstanding
      drained = 0;
      while ((request_backlog.size() != 0 || req_tvalid || predicted_lookups.size() != 0)
             && drained < DRAIN_LIMIT) begin
         @(posedge clock);
         drained++;
      end
      repeat (10) @(posedge clock);
      while (predicted_lookups.size() != 0) begin
         leftover = predicted_lookups.pop_front();
         report_mismatch("response never arrived", leftover.value, '0);
      end
      if (request_backlog.size() != 0)
         report_mismatch("requests never accepted", request_backlog.size(), '0);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
